// ===== rtl/vfv_pkg.sv =====
// Shared types and codes for the voxel face visibility block.
// No dependencies; used by vfv_addr and voxel_face_visibility.
`default_nettype none

package vfv_pkg;

  // request kinds carried in s_axis_tuser
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_SIZE_X = 2'd0;
  localparam logic [1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [1:0] CFG_SIZE_Z = 2'd2;

  localparam int NUM_FACES = 6;
  localparam int CFG_BITS  = 5;
  localparam int VAL_BITS  = 9;

  // all ones: read or query of a coordinate outside the chunk
  localparam logic [VAL_BITS-1:0] VAL_OUT_OF_RANGE = '1;

  // face bit order: left, right, bottom, top, back, front
  typedef struct packed {
    logic                 ok;
    logic [NUM_FACES-1:0] nb_in;
  } vox_flags_t;

endpackage

`default_nettype wire

// ===== rtl/vfv_addr.sv =====
// Coordinate checker and store address generator.
// Depends on vfv_pkg for the flag struct.
`default_nettype none

module vfv_addr #(
  parameter int MAX_EDGE = 16
) (
  input  wire logic signed [7:0]                          coord_x,
  input  wire logic signed [7:0]                          coord_y,
  input  wire logic signed [7:0]                          coord_z,
  input  wire logic [$clog2(MAX_EDGE+1)-1:0]              eff_x,
  input  wire logic [$clog2(MAX_EDGE+1)-1:0]              eff_y,
  input  wire logic [$clog2(MAX_EDGE+1)-1:0]              eff_z,
  input  wire logic [$clog2(MAX_EDGE*MAX_EDGE+1)-1:0]     plane,
  output vfv_pkg::vox_flags_t                             flags,
  output logic [$clog2(MAX_EDGE*MAX_EDGE*MAX_EDGE)-1:0]   addr
);

  localparam int EW = $clog2(MAX_EDGE + 1);
  localparam int CW = $clog2(MAX_EDGE);
  localparam int PW = $clog2(MAX_EDGE * MAX_EDGE + 1);
  localparam int AW = $clog2(MAX_EDGE * MAX_EDGE * MAX_EDGE);
  localparam int SW = CW + PW + 1;

  logic [7:0]       ux, uy, uz;
  logic             in_x, in_y, in_z;
  logic [CW-1:0]    cx, cy, cz;
  logic [CW+PW-1:0] px;
  logic [CW+EW-1:0] py;
  logic [SW-1:0]    sum;

  assign ux = coord_x;
  assign uy = coord_y;
  assign uz = coord_z;

  assign in_x = !ux[7] && (ux < 8'(eff_x));
  assign in_y = !uy[7] && (uy < 8'(eff_y));
  assign in_z = !uz[7] && (uz < 8'(eff_z));

  assign flags.ok = in_x && in_y && in_z;

  // interior neighbor exists on each face of an in-range voxel
  assign flags.nb_in[0] = (ux != 8'd0);
  assign flags.nb_in[1] = ((9'(ux) + 9'd1) < 9'(eff_x));
  assign flags.nb_in[2] = (uy != 8'd0);
  assign flags.nb_in[3] = ((9'(uy) + 9'd1) < 9'(eff_y));
  assign flags.nb_in[4] = (uz != 8'd0);
  assign flags.nb_in[5] = ((9'(uz) + 9'd1) < 9'(eff_z));

  // low bits are exact whenever the coordinate is in range
  assign cx = ux[CW-1:0];
  assign cy = uy[CW-1:0];
  assign cz = uz[CW-1:0];

  assign px  = cx * plane;
  assign py  = cy * eff_z;
  assign sum = SW'(px) + SW'(py) + SW'(cz);
  assign addr = AW'(sum);

endmodule

`default_nettype wire

// ===== rtl/voxel_face_visibility.sv =====
// Top level of the voxel face visibility block: voxel store, sequencer, I/O.
// Depends on vfv_pkg and vfv_addr.
`default_nettype none

// One chunk of voxel ids (MAX_EDGE^3 entries, single-port store with a
// registered read) serving write, read and face-query requests, one at a
// time. After reset a clearing pass writes air to every entry (4096 at the
// default), one per cycle; no request is taken meanwhile, configuration
// writes are. After the address phase an unused or out-of-range request
// goes straight to the done state, a write through the store write, a read
// or a query of an air voxel through the store read and a check; a query
// of a solid voxel then also reads each of the six neighbors in turn
// through the one read port and a shared neighbor address adder. The next
// request is taken in the same cycle as its result is presented, once the
// output register is free, and while that result still waits on the output
// register. Extent registers saturate at MAX_EDGE; the plane stride is
// registered from the written Y and Z extents.

module voxel_face_visibility #(
  parameter int MAX_EDGE = 16,
  parameter int ID_BITS  = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [4:0]  cfg_data,
  // request stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // coord_x[7:0], coord_y[15:8], coord_z[23:16], new_id[31:24],
  // outside_air[37:32], zero[39:38]
  input  wire logic [39:0] s_axis_tdata,
  // req_type[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // read_value[8:0], face_mask[14:9], zero[15]
  output logic [15:0]      m_axis_tdata,
  // in_range[0]
  output logic [0:0]       m_axis_tuser
);

  localparam int EW    = $clog2(MAX_EDGE + 1);
  localparam int PW    = $clog2(MAX_EDGE * MAX_EDGE + 1);
  localparam int DEPTH = MAX_EDGE * MAX_EDGE * MAX_EDGE;
  localparam int AW    = $clog2(DEPTH);
  localparam int NF    = vfv_pkg::NUM_FACES;
  localparam int VB    = vfv_pkg::VAL_BITS;
  localparam int EFF_RST = (MAX_EDGE < 16) ? MAX_EDGE : 16;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_ADDR  = 4'd2;
  localparam logic [3:0] S_WR    = 4'd3;
  localparam logic [3:0] S_RD    = 4'd4;
  localparam logic [3:0] S_CHK   = 4'd5;
  localparam logic [3:0] S_NB    = 4'd6;
  localparam logic [3:0] S_NBL   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]    state;
  logic [AW-1:0] clr_cnt;

  // extents and derived plane stride
  logic [EW-1:0] eff_x, eff_y, eff_z;
  logic [PW-1:0] plane;
  logic [EW-1:0] cfg_eff;
  logic [7:0]    cfg_wide;

  // latched request
  logic [1:0]          req;
  logic signed [7:0]   rx, ry, rz;
  logic [7:0]          rid;
  logic [NF-1:0]       routside;

  // address unit and sequencer state
  vfv_pkg::vox_flags_t flags_c, flags;
  logic [AW-1:0]       addr_c, addr;
  logic [2:0]          nb_k;
  logic [2:0]          eval_idx;
  logic [AW-1:0]       nb_off, nb_addr;

  // working and output result
  logic [VB-1:0] w_value, res_value;
  logic          w_ok, res_ok;
  logic [NF-1:0] w_mask, res_mask;

  // store
  logic [ID_BITS-1:0] mem [DEPTH];
  logic [ID_BITS-1:0] rd_data;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [ID_BITS-1:0] mem_wdata;

  logic in_xfer, out_free, face_bit;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign m_axis_tdata = {1'b0, res_mask, res_value};
  assign m_axis_tuser = res_ok;

  // ---------------- configuration ----------------
  assign cfg_wide = 8'(cfg_data);
  assign cfg_eff  = (cfg_wide > 8'(MAX_EDGE)) ? EW'(MAX_EDGE) : EW'(cfg_wide);

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_x <= EW'(EFF_RST);
      eff_y <= EW'(EFF_RST);
      eff_z <= EW'(EFF_RST);
      plane <= PW'(EFF_RST * EFF_RST);
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          vfv_pkg::CFG_SIZE_X: eff_x <= cfg_eff;
          vfv_pkg::CFG_SIZE_Y: eff_y <= cfg_eff;
          vfv_pkg::CFG_SIZE_Z: eff_z <= cfg_eff;
          default: ;
        endcase
      end
      plane <= PW'(eff_y) * PW'(eff_z);
    end
  end

  // ---------------- address unit ----------------
  vfv_addr #(
    .MAX_EDGE(MAX_EDGE)
  ) u_addr (
    .coord_x(rx),
    .coord_y(ry),
    .coord_z(rz),
    .eff_x  (eff_x),
    .eff_y  (eff_y),
    .eff_z  (eff_z),
    .plane  (plane),
    .flags  (flags_c),
    .addr   (addr_c)
  );

  // shared neighbor adder: odd faces step up, even faces step down
  always_comb begin
    case (nb_k[2:1])
      2'd0:    nb_off = AW'(plane);
      2'd1:    nb_off = AW'(eff_z);
      default: nb_off = AW'(1);
    endcase
  end
  assign nb_addr = nb_k[0] ? (addr + nb_off) : (addr - nb_off);

  assign eval_idx = (state == S_NBL) ? 3'(NF - 1) : (nb_k - 3'd1);
  assign face_bit = flags.nb_in[eval_idx] ? (rd_data == '0) : routside[eval_idx];

  // ---------------- store ----------------
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr;
    mem_wdata = ID_BITS'(rid);
    mem_re    = 1'b0;
    mem_raddr = addr;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = '0;
      end
      S_WR: mem_we = 1'b1;
      S_RD: mem_re = 1'b1;
      S_NB: begin
        mem_re    = 1'b1;
        mem_raddr = nb_addr;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data <= mem[mem_raddr];
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_cnt       <= '0;
      nb_k          <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_xfer) state <= S_ADDR;
        end
        S_ADDR: begin
          if (req == vfv_pkg::REQ_NONE) state <= S_DONE;
          else if (req == vfv_pkg::REQ_WRITE) state <= flags_c.ok ? S_WR : S_DONE;
          else state <= flags_c.ok ? S_RD : S_DONE;
        end
        S_WR: state <= S_DONE;
        S_RD: state <= S_CHK;
        S_CHK: begin
          nb_k <= '0;
          if (req == vfv_pkg::REQ_QUERY && rd_data != '0) state <= S_NB;
          else state <= S_DONE;
        end
        S_NB: begin
          nb_k <= nb_k + 3'd1;
          if (nb_k == 3'(NF - 1)) state <= S_NBL;
        end
        S_NBL: state <= S_DONE;
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // request, working and result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req      <= s_axis_tuser;
      rx       <= s_axis_tdata[7:0];
      ry       <= s_axis_tdata[15:8];
      rz       <= s_axis_tdata[23:16];
      rid      <= s_axis_tdata[31:24];
      routside <= s_axis_tdata[37:32];
    end
    case (state)
      S_ADDR: begin
        addr    <= addr_c;
        flags   <= flags_c;
        w_ok    <= flags_c.ok && (req != vfv_pkg::REQ_NONE);
        w_mask  <= '0;
        w_value <= (req != vfv_pkg::REQ_NONE && req != vfv_pkg::REQ_WRITE && !flags_c.ok) ?
                   vfv_pkg::VAL_OUT_OF_RANGE : '0;
      end
      S_CHK: w_value <= VB'(rd_data);
      S_NB: begin
        if (nb_k != 3'd0) w_mask[eval_idx] <= face_bit;
      end
      S_NBL: w_mask[eval_idx] <= face_bit;
      S_DONE: begin
        if (out_free) begin
          res_value <= w_value;
          res_ok    <= w_ok;
          res_mask  <= w_mask;
        end
      end
      default: ;
    endcase
  end

  // ---------------- checks ----------------
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR) |-> flags.ok)
    else $error("store write for a coordinate outside the chunk");

  a_mask_needs_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (res_mask == '0 || res_ok))
    else $error("face mask set on an out-of-range result");

  a_accept_to_addr: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state == S_ADDR))
    else $error("accepted request did not start address phase");

  a_face_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_NB) |-> (nb_k <= 3'(NF - 1)))
    else $error("neighbor counter past last face");

endmodule

`default_nettype wire

// ===== test/voxel_face_visibility_tb.sv =====
// Self-checking testbench for voxel_face_visibility: writes, reads and face queries
// against a cycle-free predictor of the voxel store, over several chunk extents.
// Depends on vfv_pkg and the voxel_face_visibility RTL.
`timescale 1ns / 100ps

module voxel_face_visibility_tb;

  localparam int EDGE         = 16;
  localparam int DEPTH        = EDGE * EDGE * EDGE;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 16;
  localparam int LONG_HOLD    = 300;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] z;
    logic [7:0] id;
    logic [5:0] oair;
  } voxel_req_t;

  typedef struct packed {
    logic [8:0] value;
    logic       in_range;
    logic [5:0] faces;
  } voxel_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [4:0]  cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  voxel_face_visibility #(
    .MAX_EDGE(EDGE),
    .ID_BITS (8)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // predictor state
  logic [7:0] voxels [DEPTH];
  logic [4:0] ext_x = 5'd16;
  logic [4:0] ext_y = 5'd16;
  logic [4:0] ext_z = 5'd16;

  voxel_req_t    request_queue[$];
  voxel_result_t pending_results[$];
  voxel_req_t    in_flight;

  bit offering  = 1'b0;
  bit gap_on    = 1'b0;
  bit stall_on  = 1'b0;
  int gap_left  = 0;
  int stall_left = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int base_x, base_y, base_z;

  int cycles    = 0;
  int errors    = 0;
  int n_sent    = 0;
  int n_checked = 0;
  int n_visible = 0;
  int n_cfg     = 0;

  function automatic int eff_extent(logic [4:0] s);
    return (s > EDGE) ? EDGE : int'(s);
  endfunction

  function automatic bit in_chunk(int x, int y, int z);
    return x >= 0 && y >= 0 && z >= 0 && x < eff_extent(ext_x) &&
           y < eff_extent(ext_y) && z < eff_extent(ext_z);
  endfunction

  function automatic int cell_index(int x, int y, int z);
    int i;
    i = (x * eff_extent(ext_y) + y) * eff_extent(ext_z) + z;
    return (i < DEPTH) ? i : 0;
  endfunction

  // inside neighbor: open when air; past the chunk edge the outside flag decides
  function automatic logic face_open(int x, int y, int z, logic oflag);
    if (in_chunk(x, y, z))
      return voxels[cell_index(x, y, z)] == 8'd0;
    return oflag;
  endfunction

  function automatic voxel_result_t apply_request(voxel_req_t rq);
    voxel_result_t res;
    int x, y, z;
    bit ok;
    logic [7:0] cur;
    x = int'($signed(rq.x));
    y = int'($signed(rq.y));
    z = int'($signed(rq.z));
    ok = in_chunk(x, y, z);
    res = '0;
    if (rq.kind == vfv_pkg::REQ_NONE)
      return res;
    res.in_range = ok;
    if (rq.kind == vfv_pkg::REQ_WRITE) begin
      if (ok)
        voxels[cell_index(x, y, z)] = rq.id;
    end else if (!ok) begin
      res.value = vfv_pkg::VAL_OUT_OF_RANGE;
    end else begin
      cur = voxels[cell_index(x, y, z)];
      res.value = {1'b0, cur};
      if (rq.kind == vfv_pkg::REQ_QUERY && cur != 8'd0) begin
        res.faces[0] = face_open(x - 1, y, z, rq.oair[0]);
        res.faces[1] = face_open(x + 1, y, z, rq.oair[1]);
        res.faces[2] = face_open(x, y - 1, z, rq.oair[2]);
        res.faces[3] = face_open(x, y + 1, z, rq.oair[3]);
        res.faces[4] = face_open(x, y, z - 1, rq.oair[4]);
        res.faces[5] = face_open(x, y, z + 1, rq.oair[5]);
      end
    end
    return res;
  endfunction

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_base(logic [4:0] s);
    int e;
    e = eff_extent(s);
    return (e <= 4) ? 0 : $urandom_range(0, e - 4);
  endfunction

  // mostly a 4-wide window inside the chunk so that solids cluster,
  // some just past either edge, some anywhere in the byte
  function automatic logic [7:0] pick_axis(logic [4:0] s, int base);
    int r, e, hi;
    e = eff_extent(s);
    r = $urandom_range(0, 99);
    if (e == 0 || r >= 92)
      return 8'($urandom_range(0, 255));
    if (r >= 84)
      return r[0] ? 8'(e) : 8'hFF;
    hi = (base + 3 < e - 1) ? base + 3 : e - 1;
    return 8'($urandom_range(base, hi));
  endfunction

  function automatic voxel_req_t random_req();
    voxel_req_t rq;
    int r;
    r = $urandom_range(0, 99);
    if (r < 40)      rq.kind = vfv_pkg::REQ_WRITE;
    else if (r < 55) rq.kind = vfv_pkg::REQ_READ;
    else if (r < 95) rq.kind = vfv_pkg::REQ_QUERY;
    else             rq.kind = vfv_pkg::REQ_NONE;
    rq.x = pick_axis(ext_x, base_x);
    rq.y = pick_axis(ext_y, base_y);
    rq.z = pick_axis(ext_z, base_z);
    rq.id = ($urandom_range(0, 99) < 30) ? 8'd0 : 8'($urandom_range(1, 255));
    rq.oair = 6'($urandom_range(0, 63));
    return rq;
  endfunction

  task automatic push_req(input logic [1:0] kind, input int x, input int y, input int z,
                          input logic [7:0] id, input logic [5:0] oair);
    voxel_req_t rq;
    rq.kind = kind;
    rq.x = 8'(x);
    rq.y = 8'(y);
    rq.z = 8'(z);
    rq.id = id;
    rq.oair = oair;
    request_queue = {request_queue, rq};
  endtask

  task automatic report_mismatch(input string msg);
    errors++;
    $display("MISMATCH cycle %0d: %s", cycles, msg);
  endtask

  task automatic set_extent(input logic [1:0] idx, input logic [4:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      vfv_pkg::CFG_SIZE_X: ext_x = val;
      vfv_pkg::CFG_SIZE_Y: ext_y = val;
      vfv_pkg::CFG_SIZE_Z: ext_z = val;
      default: ;
    endcase
    n_cfg++;
  endtask

  task automatic wait_drain();
    while (request_queue.size() != 0 || offering || pending_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [4:0] sx, input logic [4:0] sy, input logic [4:0] sz,
                           input int count, input bit gaps, input bit long_hold);
    int i;
    set_extent(vfv_pkg::CFG_SIZE_X, sx);
    set_extent(vfv_pkg::CFG_SIZE_Y, sy);
    set_extent(vfv_pkg::CFG_SIZE_Z, sz);
    repeat (2) @(posedge clk);
    base_x = pick_base(sx);
    base_y = pick_base(sy);
    base_z = pick_base(sz);
    gap_on = gaps;
    stall_on = gaps;
    if (long_hold)
      hold_asks++;
    for (i = 0; i < count; i++)
      request_queue = {request_queue, random_req()};
    wait_drain();
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      offering = 1'b0;
      gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        pending_results = {pending_results, apply_request(in_flight)};
        n_sent++;
        offering = 1'b0;
        gap_left = gap_on ? draw_gap() : 0;
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_queue.size() != 0) begin
          in_flight = request_queue.pop_front();
          s_axis_tdata <= {2'b00, in_flight.oair, in_flight.id, in_flight.z, in_flight.y,
                           in_flight.x};
          s_axis_tuser <= in_flight.kind;
          offering = 1'b1;
        end
      end
      s_axis_tvalid <= offering;
    end
  end

  // result-side backpressure; a long hold is requested by bumping hold_asks
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!stall_on) begin
        m_axis_tready <= 1'b1;
      end else begin
        stall_left = draw_gap();
        m_axis_tready <= (stall_left == 0);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : check_results
    voxel_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with nothing outstanding");
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (want.faces != 6'd0)
          n_visible++;
        if (m_axis_tdata[8:0] !== want.value)
          report_mismatch($sformatf("read_value got %h want %h", m_axis_tdata[8:0],
                                    want.value));
        if (m_axis_tuser[0] !== want.in_range)
          report_mismatch($sformatf("in_range got %b want %b", m_axis_tuser[0],
                                    want.in_range));
        if (m_axis_tdata[14:9] !== want.faces)
          report_mismatch($sformatf("face_mask got %b want %b", m_axis_tdata[14:9],
                                    want.faces));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int k;
    foreach (voxels[i])
      voxels[i] = 8'd0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    gap_on = 1'b1;
    stall_on = 1'b1;

    // directed: corners, far out of range, edges from the outside flags
    push_req(vfv_pkg::REQ_WRITE, 0, 0, 0, 8'd255, 6'd0);
    push_req(vfv_pkg::REQ_WRITE, 15, 15, 15, 8'd1, 6'd0);
    push_req(vfv_pkg::REQ_WRITE, -128, 0, 0, 8'd9, 6'd63);
    push_req(vfv_pkg::REQ_WRITE, 127, 127, 127, 8'd9, 6'd0);
    push_req(vfv_pkg::REQ_WRITE, 0, -128, 16, 8'd9, 6'd0);
    push_req(vfv_pkg::REQ_READ, 0, 0, 0, 8'd0, 6'd0);
    push_req(vfv_pkg::REQ_READ, 15, 15, 15, 8'd0, 6'd0);
    push_req(vfv_pkg::REQ_READ, -1, 0, 0, 8'd0, 6'd0);
    push_req(vfv_pkg::REQ_READ, 0, 16, 0, 8'd0, 6'd0);
    push_req(vfv_pkg::REQ_READ, 0, 0, 127, 8'd0, 6'd0);
    push_req(vfv_pkg::REQ_QUERY, 0, 0, 0, 8'd0, 6'b101010);
    push_req(vfv_pkg::REQ_QUERY, 0, 0, 0, 8'd0, 6'b010101);
    push_req(vfv_pkg::REQ_QUERY, 15, 15, 15, 8'd0, 6'b000000);
    push_req(vfv_pkg::REQ_QUERY, 15, 15, 15, 8'd0, 6'b111111);
    push_req(vfv_pkg::REQ_WRITE, 1, 0, 0, 8'd7, 6'd0);
    push_req(vfv_pkg::REQ_QUERY, 0, 0, 0, 8'd0, 6'b111111);
    push_req(vfv_pkg::REQ_QUERY, 5, 5, 5, 8'd0, 6'b111111);
    push_req(vfv_pkg::REQ_QUERY, -128, -128, -128, 8'd0, 6'b111111);
    push_req(vfv_pkg::REQ_QUERY, 16, 0, 0, 8'd0, 6'b111111);
    push_req(vfv_pkg::REQ_NONE, 3, 4, 5, 8'd200, 6'b111111);
    push_req(vfv_pkg::REQ_WRITE, 15, 15, 15, 8'd0, 6'd0);
    push_req(vfv_pkg::REQ_READ, 15, 15, 15, 8'd0, 6'd0);
    push_req(vfv_pkg::REQ_READ, 1, 0, 0, 8'd0, 6'd0);
    push_req(vfv_pkg::REQ_QUERY, 1, 0, 0, 8'd0, 6'b000000);
    push_req(vfv_pkg::REQ_WRITE, 7, 8, 9, 8'd128, 6'd0);
    wait_drain();

    // smallest chunk, zero and saturating extents, a long output hold, then mixed and random extents
    run_phase(5'd1, 5'd1, 5'd1, 60, 1'b1, 1'b0);
    run_phase(5'd0, 5'd16, 5'd31, 40, 1'b1, 1'b0);
    run_phase(5'd31, 5'd31, 5'd31, 250, 1'b0, 1'b1);
    run_phase(5'd2, 5'd3, 5'd5, 200, 1'b1, 1'b0);
    run_phase(5'd16, 5'd1, 5'd16, 150, 1'b1, 1'b0);
    for (k = 0; k < 4; k++)
      run_phase(5'($urandom_range(1, 16)), 5'($urandom_range(1, 16)),
                5'($urandom_range(1, 16)), 150, k[0], 1'b0);

    $display("Sent %0d requests over %0d extent writes, incl. zero and saturating sizes",
             n_sent, n_cfg);
    $display("Checked %0d results, %0d with visible faces, %0d mismatches",
             n_checked, n_visible, errors);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
